FILE: src/npab_pkg.sv
// shared types and constants for the non-premultiplied alpha blend pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package npab_pkg;

	localparam int CHAN_W      = 8;
	localparam int RECIP_SHIFT = 24;
	localparam int QUO_W       = RECIP_SHIFT + 1;
	localparam int SUM_W       = 2 * CHAN_W + 1;
	localparam int PROD_W      = SUM_W + QUO_W;
	localparam int DIV_STEPS   = 6;
	localparam int DIV_CELLS   = RECIP_SHIFT / DIV_STEPS;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [CHAN_W:0]   ALPHA_ONE    = 9'd256;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pix_t;

	// after the first stage: both pixels, weighted dst alpha, result alpha and the opaque and clear flags
	typedef struct packed {
		pix_t              src;
		pix_t              dst;
		logic [CHAN_W-1:0] df;
		logic [CHAN_W-1:0] oa;
		logic              opaque;
		logic              clear;
	} s1_t;

	// what rides along the reciprocal chain
	typedef struct packed {
		pix_t             bypass;
		logic             use_bypass;
		logic [CHAN_W-1:0] oa;
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
	} pay_t;

	// partial restoring division of 2^24 by the result alpha
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_t;

endpackage

`default_nettype wire

FILE: src/npab_cell.sv
// one elastic pipeline register with valid and ready
// no dependencies beyond the package
`timescale 1ns / 1ps
`default_nettype none

module npab_cell
	import npab_pkg::*;
#(
	parameter int W = CHAN_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	logic         valid_q;
	logic [W-1:0] data_q;

	// take a new request when empty or when the neighbor drains us
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

`default_nettype wire

FILE: src/npab_div_cell.sv
// one cell of the reciprocal chain: DIV_STEPS restoring division steps
// depends on npab_pkg and npab_cell
`timescale 1ns / 1ps
`default_nettype none

module npab_div_cell
	import npab_pkg::*;
#(
	parameter int PW = $bits(pay_t)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire div_t              in_state,
	input  wire logic [PW-1:0]     in_pay,
	input  wire logic [CHAN_W-1:0] divisor,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output div_t                   out_state,
	output logic [PW-1:0]          out_pay
);

	localparam int SW = $bits(div_t);

	div_t              nxt;
	logic [CHAN_W:0]   trial;
	logic [CHAN_W-1:0] rem;
	logic [QUO_W-1:0]  quo;
	logic [SW+PW-1:0]  cell_out;

	// dividend bits below the leading one are all zero
	always_comb begin
		rem = in_state.rem;
		quo = in_state.quo;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem, 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quo   = {quo[QUO_W-2:0], 1'b1};
			end else begin
				quo   = {quo[QUO_W-2:0], 1'b0};
			end
			rem = trial[CHAN_W-1:0];
		end
		nxt.rem = rem;
		nxt.quo = quo;
	end

	npab_cell #(
		.W(SW + PW)
	) u_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  ({nxt, in_pay}),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (cell_out)
	);

	assign out_state = cell_out[SW+PW-1:PW];
	assign out_pay   = cell_out[PW-1:0];

endmodule

`default_nettype wire

FILE: src/non_premultiplied_alpha_blend.sv
// top level: non-premultiplied rgba blend, source over destination
// depends on npab_pkg, npab_cell and npab_div_cell
`timescale 1ns / 1ps
`default_nettype none

//  channel  | signals                         | direction | request content
//  ---------+---------------------------------+-----------+--------------------------
//  pixel    | pix_valid, pix_stall            | in        | src_* and dst_* rgba
//  result   | res_valid, res_stall            | out       | out_* rgba
//
// one request accepted per clock while pix_stall is low
// six registers in a row: entry, four reciprocal cells of six quotient bits each, output
// cells hand their contents on whenever the next cell can take them; each holds one request, so bubbles
// close up and a stalled result blocks the input only once the whole row is full
// arst_n clears all valid flags; payload registers are not reset

module non_premultiplied_alpha_blend
	import npab_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire logic [CHAN_W-1:0] src_red,
	input  wire logic [CHAN_W-1:0] src_green,
	input  wire logic [CHAN_W-1:0] src_blue,
	input  wire logic [CHAN_W-1:0] src_alpha,
	input  wire logic [CHAN_W-1:0] dst_red,
	input  wire logic [CHAN_W-1:0] dst_green,
	input  wire logic [CHAN_W-1:0] dst_blue,
	input  wire logic [CHAN_W-1:0] dst_alpha,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [CHAN_W-1:0]      out_red,
	output logic [CHAN_W-1:0]      out_green,
	output logic [CHAN_W-1:0]      out_blue,
	output logic [CHAN_W-1:0]      out_alpha
);

	localparam int S1W = $bits(s1_t);
	localparam int PW  = $bits(pay_t);

	// ---------------- stage 1: weighted destination alpha ----------------
	s1_t               s1_in;
	s1_t               s1;
	logic [SUM_W-1:0]  df_full;
	logic [CHAN_W:0]   oa_sum;
	logic              s1_in_ready;
	logic              s1_valid;
	logic              s1_ready;
	logic [S1W-1:0]    s1_data;

	always_comb begin
		// dst_alpha * (256 - src_alpha), keep the upper byte
		df_full = {{(SUM_W-CHAN_W){1'b0}}, dst_alpha}
			* {{(SUM_W-CHAN_W-1){1'b0}}, ALPHA_ONE - {1'b0, src_alpha}};
		oa_sum  = {1'b0, src_alpha} + {1'b0, df_full[2*CHAN_W-1:CHAN_W]};

		s1_in.src    = '{red: src_red, green: src_green, blue: src_blue, alpha: src_alpha};
		s1_in.dst    = '{red: dst_red, green: dst_green, blue: dst_blue, alpha: dst_alpha};
		s1_in.df     = df_full[2*CHAN_W-1:CHAN_W];
		// result alpha always fits in a byte
		s1_in.oa     = oa_sum[CHAN_W-1:0];
		s1_in.opaque = (src_alpha == ALPHA_OPAQUE);
		s1_in.clear  = (src_alpha == ALPHA_CLEAR);
	end

	npab_cell #(
		.W(S1W)
	) u_s1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_valid),
		.in_ready (s1_in_ready),
		.in_data  (s1_in),
		.out_valid(s1_valid),
		.out_ready(s1_ready),
		.out_data (s1_data)
	);

	assign pix_stall = !s1_in_ready;
	assign s1        = s1_data;

	// ---------------- weighted colour sums, division setup ----------------
	pay_t pay_c   [DIV_CELLS+1];
	div_t state_c [DIV_CELLS+1];
	logic valid_c [DIV_CELLS+1];
	logic ready_c [DIV_CELLS+1];

	function automatic logic [SUM_W-1:0] wsum(
		input logic [CHAN_W-1:0] s,
		input logic [CHAN_W-1:0] sa,
		input logic [CHAN_W-1:0] d,
		input logic [CHAN_W-1:0] df
	);
		logic [SUM_W-1:0] ps;
		logic [SUM_W-1:0] pd;
		ps = {{(SUM_W-CHAN_W){1'b0}}, s} * {{(SUM_W-CHAN_W){1'b0}}, sa};
		pd = {{(SUM_W-CHAN_W){1'b0}}, d} * {{(SUM_W-CHAN_W){1'b0}}, df};
		return ps + pd;
	endfunction

	always_comb begin
		pay_c[0].bypass     = s1.opaque ? s1.src : s1.dst;
		pay_c[0].use_bypass = s1.opaque || s1.clear;
		pay_c[0].oa         = s1.oa;
		pay_c[0].sum_red    = wsum(s1.src.red,   s1.src.alpha, s1.dst.red,   s1.df);
		pay_c[0].sum_green  = wsum(s1.src.green, s1.src.alpha, s1.dst.green, s1.df);
		pay_c[0].sum_blue   = wsum(s1.src.blue,  s1.src.alpha, s1.dst.blue,  s1.df);

		// leading dividend bit handled here: it only divides out when alpha is one
		state_c[0].quo = {{(QUO_W-1){1'b0}}, s1.oa == {{(CHAN_W-1){1'b0}}, 1'b1}};
		state_c[0].rem = (s1.oa == {{(CHAN_W-1){1'b0}}, 1'b1}) ? '0
			: {{(CHAN_W-1){1'b0}}, 1'b1};
	end

	assign valid_c[0] = s1_valid;
	assign s1_ready   = ready_c[0];

	// ---------------- reciprocal chain ----------------
	// each cell appends DIV_STEPS quotient bits of floor(2^24 / oa)
	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
		logic [PW-1:0] pay_o;

		npab_div_cell #(
			.PW(PW)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[k]),
			.in_ready (ready_c[k]),
			.in_state (state_c[k]),
			.in_pay   (pay_c[k]),
			.divisor  (pay_c[k].oa),
			.out_valid(valid_c[k+1]),
			.out_ready(ready_c[k+1]),
			.out_state(state_c[k+1]),
			.out_pay  (pay_o)
		);

		assign pay_c[k+1] = pay_o;
	end

	// ---------------- scale and output register ----------------
	pay_t             pe;
	logic [QUO_W-1:0] scale;
	logic [PROD_W-1:0] prod_red;
	logic [PROD_W-1:0] prod_green;
	logic [PROD_W-1:0] prod_blue;
	pix_t             res_in;
	logic [$bits(pix_t)-1:0] res_data;
	pix_t             res;

	assign pe    = pay_c[DIV_CELLS];
	assign scale = state_c[DIV_CELLS].quo;

	always_comb begin
		prod_red   = {{(PROD_W-SUM_W){1'b0}}, pe.sum_red}   * {{(PROD_W-QUO_W){1'b0}}, scale};
		prod_green = {{(PROD_W-SUM_W){1'b0}}, pe.sum_green} * {{(PROD_W-QUO_W){1'b0}}, scale};
		prod_blue  = {{(PROD_W-SUM_W){1'b0}}, pe.sum_blue}  * {{(PROD_W-QUO_W){1'b0}}, scale};

		if (pe.use_bypass) begin
			res_in = pe.bypass;
		end else begin
			res_in.red   = prod_red[RECIP_SHIFT +: CHAN_W];
			res_in.green = prod_green[RECIP_SHIFT +: CHAN_W];
			res_in.blue  = prod_blue[RECIP_SHIFT +: CHAN_W];
			res_in.alpha = pe.oa;
		end
	end

	npab_cell #(
		.W($bits(pix_t))
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[DIV_CELLS]),
		.in_ready (ready_c[DIV_CELLS]),
		.in_data  (res_in),
		.out_valid(res_valid),
		.out_ready(!res_stall),
		.out_data (res_data)
	);

	assign res       = res_data;
	assign out_red   = res.red;
	assign out_green = res.green;
	assign out_blue  = res.blue;
	assign out_alpha = res.alpha;

endmodule

`default_nettype wire
